// ===== hw/rtl/skm_pkg.sv =====
// Shared types and constants for the session keepalive monitor.
// Holds input kinds, event codes, register indexes and register reset values.
// No dependencies.
package skm_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned ID_W       = 32;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned PORT_W     = 16;
    localparam int unsigned CHAN_W     = 16;
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned MISS_W     = 8;
    localparam int unsigned INTERVAL_W = 22;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 22;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_PONG = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        EV_ADDED = 3'd0,
        EV_FULL  = 3'd1,
        EV_PROBE = 3'd2,
        EV_DEAD  = 3'd3,
        EV_DONE  = 3'd4
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROBE_INTERVAL = 2'd0,
        REG_DEAD_TIMEOUT   = 2'd1,
        REG_MISS_LIMIT     = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_index_t;

    localparam logic [INTERVAL_W-1:0] PROBE_INTERVAL_RST = 22'd10000;
    localparam logic [INTERVAL_W-1:0] DEAD_TIMEOUT_RST   = 22'd30000;
    localparam logic [MISS_W-1:0]     MISS_LIMIT_RST     = 8'd3;

endpackage

// ===== hw/rtl/session_keepalive_monitor_core.sv =====
// Session keepalive monitor: a table of sessions with probe and liveness timing.
// Depends on skm_pkg for kinds, event codes and register definitions.
//
// Channel   Direction  Signals                                   Word
// s_axis    in         tvalid tready tdata[127:0] tuser[1:0]     add, pong or scan tick
// m_axis    out        tvalid tready tdata[127:0] tuser[2:0]     event, tlast on final
// cfg       in         valid ready index[1:0] data[21:0]         register write
//
// A pong walks the entries until one matches or the fill count is reached. A tick walks
// the used entries, skips dead ones and puts each live one through the probe check and
// then the death check, in turn on the single shared subtract and compare unit.
// Reset clears the sequencer and the fill count and loads the registers with their
// reset values; the table needs no clearing. A stalled output holds the sequencer,
// when it has a word to emit, in place until the held word is taken.
module session_keepalive_monitor_core
    import skm_pkg::*;
#(
    parameter int unsigned SESSIONS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // session identifier, peer address, UDP port, socket handle, time in ms
    input  logic [127:0]          s_axis_tdata,
    // kind
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // event_session, probe_sequence, probe_address, probe_port, probe_channel
    output logic [127:0]          m_axis_tdata,
    // event_res
    output logic [2:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned CW = $clog2(SESSIONS + 1);
    localparam int unsigned IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_PONG  = 6'b000100,
        S_PROBE = 6'b001000,
        S_DEAD  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] used_reg, used_next;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [INTERVAL_W-1:0] timeout_reg;
    logic [MISS_W-1:0]     limit_reg;

    logic [ID_W-1:0]   sid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PORT_W-1:0] port_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic [TIME_W-1:0] now_reg;

    logic [ID_W-1:0]   ids_reg     [SESSIONS];
    logic [ADDR_W-1:0] addrs_reg   [SESSIONS];
    logic [PORT_W-1:0] ports_reg   [SESSIONS];
    logic [CHAN_W-1:0] chans_reg   [SESSIONS];
    logic [TIME_W-1:0] sent_reg    [SESSIONS];
    logic [TIME_W-1:0] heard_reg   [SESSIONS];
    logic              alive_reg   [SESSIONS];
    logic [MISS_W-1:0] miss_reg    [SESSIONS];
    logic [SEQ_W-1:0]  seq_reg     [SESSIONS];

    logic              out_valid_reg;
    event_t            out_res_reg;
    logic [ID_W-1:0]   out_sid_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [PORT_W-1:0] out_port_reg;
    logic [CHAN_W-1:0] out_chan_reg;
    logic              out_last_reg;

    logic [IW-1:0]       ix;
    logic                slot_free;
    logic                in_fire;
    logic                at_end;
    logic                full;
    logic [TIME_W-1:0]   op_time;
    logic [TIME_W-1:0]   diff;
    logic [INTERVAL_W:0] thr;
    logic                hit;
    logic                id_match;
    logic                is_dead_step;

    logic   emit;
    event_t emit_res;
    logic   emit_probe;
    logic   emit_last;
    logic   wr_add;
    logic   wr_pong;
    logic   wr_probe;
    logic   wr_dead;

    assign ix            = idx_reg[IW-1:0];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign at_end        = (idx_reg == used_reg);
    assign full          = (used_reg >= CW'(SESSIONS));
    assign id_match      = (ids_reg[ix] == sid_reg);
    assign is_dead_step  = (state_reg == S_DEAD);

    // Shared unit: wrapped elapsed time against a threshold; "greater than" uses threshold + 1.
    assign op_time = is_dead_step ? heard_reg[ix] : sent_reg[ix];
    assign thr     = is_dead_step ? ({1'b0, timeout_reg} + (INTERVAL_W + 1)'(1))
                                  : {1'b0, interval_reg};
    assign diff    = now_reg - op_time;
    assign hit     = (diff >= TIME_W'(thr));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        emit       = 1'b0;
        emit_res   = EV_DONE;
        emit_probe = 1'b0;
        emit_last  = 1'b0;
        wr_add     = 1'b0;
        wr_pong    = 1'b0;
        wr_probe   = 1'b0;
        wr_dead    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (kind_t'(s_axis_tuser))
                        KIND_ADD:
                        begin
                            state_next = S_ADD;
                            idx_next   = used_reg;
                        end
                        KIND_PONG:
                        begin
                            state_next = S_PONG;
                            idx_next   = '0;
                        end
                        KIND_TICK:
                        begin
                            state_next = S_PROBE;
                            idx_next   = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                    if (full)
                    begin
                        emit_res = EV_FULL;
                    end
                    else
                    begin
                        emit_res  = EV_ADDED;
                        wr_add    = 1'b1;
                        used_next = used_reg + CW'(1);
                    end
                end
            end
            S_PONG:
            begin
                if (at_end)
                begin
                    state_next = S_IDLE;
                end
                else if (id_match)
                begin
                    wr_pong    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_PROBE:
            begin
                if (at_end)
                begin
                    state_next = S_DONE;
                end
                else if (!alive_reg[ix])
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else if (!hit)
                begin
                    state_next = S_DEAD;
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_res   = EV_PROBE;
                    emit_probe = 1'b1;
                    wr_probe   = 1'b1;
                    state_next = S_DEAD;
                end
            end
            S_DEAD:
            begin
                if (miss_reg[ix] >= limit_reg && hit)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        emit_res   = EV_DEAD;
                        wr_dead    = 1'b1;
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_PROBE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_PROBE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_res   = EV_DONE;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            interval_reg  <= PROBE_INTERVAL_RST;
            timeout_reg   <= DEAD_TIMEOUT_RST;
            limit_reg     <= MISS_LIMIT_RST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            used_reg  <= used_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_PROBE_INTERVAL: interval_reg <= cfg_data;
                    REG_DEAD_TIMEOUT:   timeout_reg  <= cfg_data;
                    REG_MISS_LIMIT:     limit_reg    <= cfg_data[MISS_W-1:0];
                    default:            limit_reg    <= limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sid_reg  <= s_axis_tdata[31:0];
            addr_reg <= s_axis_tdata[63:32];
            port_reg <= s_axis_tdata[79:64];
            chan_reg <= s_axis_tdata[95:80];
            now_reg  <= s_axis_tdata[127:96];
        end
        if (wr_add)
        begin
            ids_reg[ix]   <= sid_reg;
            addrs_reg[ix] <= addr_reg;
            ports_reg[ix] <= port_reg;
            chans_reg[ix] <= chan_reg;
            sent_reg[ix]  <= now_reg;
            heard_reg[ix] <= now_reg;
            alive_reg[ix] <= 1'b1;
            miss_reg[ix]  <= '0;
            seq_reg[ix]   <= '0;
        end
        if (wr_pong)
        begin
            heard_reg[ix] <= now_reg;
            miss_reg[ix]  <= '0;
        end
        if (wr_probe)
        begin
            seq_reg[ix]  <= seq_reg[ix] + SEQ_W'(1);
            sent_reg[ix] <= now_reg;
            if (miss_reg[ix] != {MISS_W{1'b1}})
            begin
                miss_reg[ix] <= miss_reg[ix] + MISS_W'(1);
            end
        end
        if (wr_dead)
        begin
            alive_reg[ix] <= 1'b0;
        end
        if (emit)
        begin
            out_res_reg  <= emit_res;
            out_last_reg <= emit_last;
            out_sid_reg  <= (emit_res == EV_DONE) ? '0 : ((state_reg == S_ADD) ? sid_reg
                                                                            : ids_reg[ix]);
            out_seq_reg  <= emit_probe ? seq_reg[ix]   : '0;
            out_addr_reg <= emit_probe ? addrs_reg[ix] : '0;
            out_port_reg <= emit_probe ? ports_reg[ix] : '0;
            out_chan_reg <= emit_probe ? chans_reg[ix] : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_chan_reg, out_port_reg, out_addr_reg, out_seq_reg, out_sid_reg};

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(SESSIONS))
        else $error("fill count exceeds table size");

    a_dead_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DEAD |-> idx_reg < used_reg)
        else $error("death check outside used entries");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE || state_reg == S_PONG) |-> idx_reg <= used_reg)
        else $error("walk index passed fill count");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser == EV_ADDED || m_axis_tuser == EV_FULL || m_axis_tuser == EV_DONE))
        else $error("final word carries a probe or death event");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(out_sid_reg) && $stable(out_res_reg))
        else $error("held output word was overwritten");

endmodule

// ===== tb/session_keepalive_monitor_core_tb.sv =====
// Self-checking testbench for session_keepalive_monitor_core: adds, pongs and scan ticks
// are streamed in while a scoreboard class predicts every event word and checks it.
// Depends on skm_pkg and the session_keepalive_monitor_core RTL.
module session_keepalive_monitor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skm_pkg::*;

    localparam int SESSIONS = 16;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] sid;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] chan;
        logic [31:0] now;
    } ka_word_t;

    typedef struct {
        event_t      res;
        logic [31:0] session;
        logic [31:0] seq;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] chan;
        logic        last;
    } ka_event_t;

    class keepalive_tracker;
        logic [31:0] ids[SESSIONS];
        logic [31:0] addrs[SESSIONS];
        logic [15:0] ports[SESSIONS];
        logic [15:0] chans[SESSIONS];
        logic [31:0] sent[SESSIONS];
        logic [31:0] heard[SESSIONS];
        logic [31:0] seqs[SESSIONS];
        logic [7:0]  misses[SESSIONS];
        bit          alive[SESSIONS];
        int          used;
        logic [21:0] interval;
        logic [21:0] timeout;
        logic [7:0]  limit;
        ka_event_t   awaited[$];
        int          failures;

        function new();
            used = 0;
            interval = PROBE_INTERVAL_RST;
            timeout = DEAD_TIMEOUT_RST;
            limit = MISS_LIMIT_RST;
            failures = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [21:0] value);
            case (idx)
                REG_PROBE_INTERVAL: interval = value;
                REG_DEAD_TIMEOUT:   timeout = value;
                REG_MISS_LIMIT:     limit = value[7:0];
                default: ;
            endcase
        endfunction

        function void push_event(event_t res, logic [31:0] session, logic [31:0] seq,
                                 logic [31:0] addr, logic [15:0] port, logic [15:0] chan,
                                 logic last);
            ka_event_t e;
            e.res = res;
            e.session = session;
            e.seq = seq;
            e.addr = addr;
            e.port = port;
            e.chan = chan;
            e.last = last;
            awaited.push_back(e);
        endfunction

        function void note_word(ka_word_t w);
            logic [31:0] elapsed;
            bit found;
            found = 0;
            case (w.kind)
                KIND_ADD:
                begin
                    if (used >= SESSIONS)
                    begin
                        push_event(EV_FULL, w.sid, '0, '0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        ids[used] = w.sid;
                        addrs[used] = w.addr;
                        ports[used] = w.port;
                        chans[used] = w.chan;
                        sent[used] = w.now;
                        heard[used] = w.now;
                        alive[used] = 1'b1;
                        misses[used] = '0;
                        seqs[used] = '0;
                        used++;
                        push_event(EV_ADDED, w.sid, '0, '0, '0, '0, 1'b1);
                    end
                end
                KIND_PONG:
                begin
                    for (int i = 0; i < used; i++)
                    begin
                        if (!found && ids[i] == w.sid)
                        begin
                            heard[i] = w.now;
                            misses[i] = '0;
                            found = 1;
                        end
                    end
                end
                KIND_TICK:
                begin
                    for (int i = 0; i < used; i++)
                    begin
                        if (alive[i])
                        begin
                            elapsed = w.now - sent[i];
                            if (elapsed >= {10'd0, interval})
                            begin
                                push_event(EV_PROBE, ids[i], seqs[i], addrs[i], ports[i],
                                           chans[i], 1'b0);
                                seqs[i] = seqs[i] + 32'd1;
                                sent[i] = w.now;
                                if (misses[i] != 8'hFF)
                                begin
                                    misses[i] = misses[i] + 8'd1;
                                end
                            end
                            elapsed = w.now - heard[i];
                            if (misses[i] >= limit && elapsed > {10'd0, timeout})
                            begin
                                alive[i] = 1'b0;
                                push_event(EV_DEAD, ids[i], '0, '0, '0, '0, 1'b0);
                            end
                        end
                    end
                    push_event(EV_DONE, '0, '0, '0, '0, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void match(string field, logic [31:0] exp, logic [31:0] act);
            if (act !== exp)
            begin
                failures++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp, act);
            end
        endfunction

        function void check_event(logic [2:0] res, logic [127:0] data, logic last);
            ka_event_t e;
            if (awaited.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected word, expected none, actual res %h data %h",
                         $time, res, data);
                return;
            end
            e = awaited.pop_front();
            match("event_res", {29'd0, e.res}, {29'd0, res});
            match("event_session", e.session, data[31:0]);
            match("probe_sequence", e.seq, data[63:32]);
            match("probe_address", e.addr, data[95:64]);
            match("probe_port", {16'd0, e.port}, {16'd0, data[111:96]});
            match("probe_channel", {16'd0, e.chan}, {16'd0, data[127:112]});
            match("last", {31'd0, e.last}, {31'd0, last});
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [127:0]          s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [127:0]          m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    keepalive_tracker tracker;
    logic [31:0]      clock_ms;
    bit               quiet = 1'b0;
    int               rx_hold = 0;
    int unsigned      cycles = 0;

    session_keepalive_monitor_core #(
        .SESSIONS(SESSIONS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(99);
        if (r < 75)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            tracker.check_event(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
        if (rx_hold != 0)
        begin
            rx_hold--;
        end
        else if (!quiet)
        begin
            rx_hold = idle_span();
        end
        m_axis_tready <= (rx_hold == 0);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("session_keepalive_monitor_core_tb NOT OK");
            $finish;
        end
    end

    task automatic send_word(kind_t kind, logic [31:0] sid, logic [31:0] addr,
                             logic [15:0] port, logic [15:0] chan, logic [31:0] now);
        ka_word_t w;
        int gap;
        w = '{kind, sid, addr, port, chan, now};
        gap = quiet ? 0 : idle_span();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {now, chan, port, addr, sid};
        do @(posedge clk); while (!s_axis_tready);
        tracker.note_word(w);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.awaited.size() != 0);
    endtask

    task automatic wait_idle();
        drain();
        repeat (64) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [21:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_reg(idx, value);
    endtask

    task automatic program_regs(logic [21:0] interval, logic [21:0] timeout,
                                logic [7:0] limit, bit touch_unused);
        wait_idle();
        write_reg(REG_PROBE_INTERVAL, interval);
        write_reg(REG_DEAD_TIMEOUT, timeout);
        write_reg(REG_MISS_LIMIT, {14'd0, limit});
        if (touch_unused)
        begin
            write_reg(REG_UNUSED, 22'($urandom));
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(int count, int cap, int w_add, int w_pong, int w_tick,
                             int unsigned step_lo, int unsigned step_hi);
        int r;
        int pick;
        logic [31:0] sid;
        for (int n = 0; n < count; n++)
        begin
            clock_ms = clock_ms + $urandom_range(step_hi, step_lo);
            r = $urandom_range(99);
            pick = $urandom_range(w_add + w_pong + w_tick - 1);
            if (r < 3)
            begin
                send_word(KIND_NONE, $urandom, $urandom, 16'($urandom), 16'($urandom),
                          $urandom);
            end
            else if (r < 6)
            begin
                send_word(KIND_PONG, $urandom, $urandom, 16'($urandom), 16'($urandom),
                          clock_ms);
            end
            else if (pick < w_add && tracker.used < cap)
            begin
                sid = $urandom;
                if (tracker.used > 0 && $urandom_range(9) == 0)
                begin
                    sid = tracker.ids[$urandom_range(tracker.used - 1)];
                end
                send_word(KIND_ADD, sid, $urandom, 16'($urandom), 16'($urandom), clock_ms);
            end
            else if (pick < w_add + w_pong && tracker.used > 0)
            begin
                send_word(KIND_PONG, tracker.ids[$urandom_range(tracker.used - 1)],
                          $urandom, 16'($urandom), 16'($urandom), clock_ms);
            end
            else
            begin
                send_word(KIND_TICK, $urandom, $urandom, 16'($urandom), 16'($urandom),
                          clock_ms);
            end
            if ($urandom_range(49) == 0)
            begin
                drain();
            end
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values, a table that wraps time, duplicate ids, a dead peer.
        clock_ms = 32'hFFFF_FFF0;
        send_word(KIND_TICK, '0, '0, '0, '0, clock_ms);
        send_word(KIND_ADD, '1, '1, '1, '1, clock_ms);
        send_word(KIND_ADD, '0, '0, '0, '0, clock_ms);
        send_word(KIND_ADD, '1, 32'h1234_5678, 16'h00FF, 16'hFF00, clock_ms);
        send_word(KIND_NONE, '1, '1, '1, '1, '1);
        send_word(KIND_PONG, '1, '0, '0, '0, clock_ms + 5000);
        send_word(KIND_PONG, 32'h5A5A_5A5A, '0, '0, '0, clock_ms + 5000);
        send_word(KIND_TICK, '0, '0, '0, '0, clock_ms + 9999);
        send_word(KIND_TICK, '0, '0, '0, '0, clock_ms + 10000);
        send_word(KIND_TICK, '0, '0, '0, '0, clock_ms + 20000);
        send_word(KIND_TICK, '0, '0, '0, '0, clock_ms + 30000);
        send_word(KIND_TICK, '0, '0, '0, '0, clock_ms + 30001);
        send_word(KIND_TICK, '0, '0, '0, '0, clock_ms + 40000);
        send_word(KIND_PONG, '0, '0, '0, '0, clock_ms + 40000);
        send_word(KIND_TICK, '1, '1, '1, '1, clock_ms + 50000);
        clock_ms = clock_ms + 50000;

        program_regs(22'($urandom_range(40, 5)), 22'($urandom_range(150, 20)),
                     8'($urandom_range(4, 1)), 0);
        run_phase(40, 8, 15, 30, 55, 0, 20);

        // Many probes with no reply drive the miss counts into saturation.
        quiet = 1'b1;
        program_regs(22'd1, 22'd3600000, 8'd255, 0);
        run_phase(4, 12, 100, 0, 0, 1, 1);
        run_phase(262, 12, 0, 0, 100, 1, 1);
        quiet = 1'b0;

        program_regs(22'd3600000, 22'd3600000, 8'd255, 0);
        run_phase(20, 14, 10, 20, 70, 0, 4000000);

        for (int p = 0; p < 3; p++)
        begin
            program_regs(22'($urandom_range(200, 1)), 22'($urandom_range(600, 1)),
                         8'($urandom_range(8, 1)), p == 1);
            run_phase(15, 15, 12, 30, 58, 0, 100);
        end

        program_regs(22'd1, 22'd1, 8'd1, 0);
        run_phase(20, 16, 40, 20, 40, 0, 100);
        while (tracker.used < SESSIONS)
        begin
            send_word(KIND_ADD, $urandom, $urandom, 16'($urandom), 16'($urandom), clock_ms);
        end
        send_word(KIND_ADD, $urandom, $urandom, 16'($urandom), 16'($urandom), clock_ms);
        send_word(KIND_ADD, $urandom, $urandom, 16'($urandom), 16'($urandom), clock_ms);
        send_word(KIND_TICK, $urandom, $urandom, 16'($urandom), 16'($urandom),
                  clock_ms + 50);

        wait_idle();
        if (tracker.failures == 0 && tracker.awaited.size() == 0)
        begin
            $display("session_keepalive_monitor_core_tb OK");
        end
        else
        begin
            $display("session_keepalive_monitor_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/skm_pkg.sv
hw/rtl/session_keepalive_monitor_core.sv
tb/session_keepalive_monitor_core_tb.sv
